/* rtl/lrq_pkg.sv */
// Shared types, widths and codes of the lottery ready-queue picker.
`timescale 1ns / 1ps
package lrq_pkg;

    // Defaults of the top-level parameters.
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // Fixed field widths.
    localparam int IN_ID_W  = 8;
    localparam int TICKET_W = 8;
    localparam int RAND_W   = 31;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Operation codes of an input item.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DRAW    = 1'b1;

    // Status codes of a result item.
    localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DRAWN    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd4;

    typedef struct packed {
        logic                operation;
        logic [IN_ID_W-1:0]  entry_id;
        logic [TICKET_W-1:0] ticket_count;
        logic [RAND_W-1:0]   random_value;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IN_ID_W-1:0]  winner_id;
        logic [TICKET_W-1:0] winner_tickets;
        logic [COUNT_W-1:0]  queue_count;
    } rsp_item_t;

endpackage

/* rtl/lrq_store.sv */
// Entry memory of the ready queue: one write port and one registered read port.
`timescale 1ns / 1ps
module lrq_store
    import lrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    localparam int IDX_W      = $clog2(QUEUE_DEPTH)
)
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  logic [ID_BITS-1:0]  wr_id,
    input  logic [TICKET_W-1:0] wr_tickets,
    input  logic [IDX_W-1:0]    rd_addr,
    output logic [ID_BITS-1:0]  rd_id,
    output logic [TICKET_W-1:0] rd_tickets
);

    logic [ID_BITS-1:0]  id_mem     [QUEUE_DEPTH];
    logic [TICKET_W-1:0] ticket_mem [QUEUE_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_addr]     <= wr_id;
            ticket_mem[wr_addr] <= wr_tickets;
        end
    end

    // Read port, data registered.
    always_ff @(posedge clk)
    begin
        rd_id      <= id_mem[rd_addr];
        rd_tickets <= ticket_mem[rd_addr];
    end

endmodule

/* rtl/lrq_modulo.sv */
// Bit-serial restoring modulo unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module lrq_modulo
    import lrq_pkg::*;
#(
    parameter int SUM_W = TICKET_W + $clog2(QUEUE_DEPTH_DEF)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAND_W-1:0] dividend,
    input  logic [SUM_W-1:0]  divisor,
    output logic              done,
    output logic [SUM_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(RAND_W);

    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  rem_next;
    logic [RAND_W-1:0] dvd_reg;
    logic [SUM_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SUM_W:0]    trial;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[RAND_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = SUM_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = SUM_W'(trial);
        end
    end

    // Operands and partial remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(RAND_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/lottery_ready_queue_pick.sv */
// Lottery pick from an ordered ready queue: sequencer, accumulator and output register.
// An enqueue item, or a draw on an empty queue, finishes in the cycle it is accepted.
// A draw runs in order through a ticket sum, a bit-serial modulo, a walk to the winner,
// a compaction of the entries behind it and a load of the result register; a zero ticket
// total goes from the sum straight to the load. One item at a time; a held result
// stalls the input. Reset clears occupancy and control; the entry memory is not cleared.
`timescale 1ns / 1ps
module lottery_ready_queue_pick
    import lrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = TICKET_W + $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_MOD,
        S_WALK,
        S_SHIFT,
        S_FINISH
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    occ_reg;
    logic [CNT_W-1:0]    issue_reg;
    logic                pend_reg;
    logic [IDX_W-1:0]    data_idx_reg;
    logic [RAND_W-1:0]   rnd_reg;
    logic [SUM_W-1:0]    total_reg;
    logic [SUM_W-1:0]    run_reg;
    logic [SUM_W-1:0]    run_next;
    logic                found_reg;
    logic [IDX_W-1:0]    win_idx_reg;
    logic [ID_BITS-1:0]  win_id_reg;
    logic [TICKET_W-1:0] win_tk_reg;
    logic [STATUS_W-1:0] st_reg;
    logic                rsp_valid_reg;
    rsp_item_t           rsp_reg;

    logic                accept;
    logic                slot_free;
    logic                rsp_load;
    logic                issue_more;
    logic                pass_done;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ID_BITS-1:0]  wr_id;
    logic [TICKET_W-1:0] wr_tickets;
    logic [ID_BITS-1:0]  rd_id;
    logic [TICKET_W-1:0] rd_tickets;
    logic                mod_start;
    logic                mod_done;
    logic [SUM_W-1:0]    mod_rem;

    // Handshake and pass control.
    assign slot_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept     = req_valid && req_ready;
    assign issue_more = issue_reg < occ_reg;
    assign pass_done  = !issue_more && !pend_reg;
    assign mod_start  = (state_reg == S_SUM) && pass_done && (total_reg != '0);

    // The result register is loaded by an immediate answer or by the end of a draw.
    assign rsp_load = (accept && ((req.operation == OP_ENQUEUE) || (occ_reg == '0)))
                    || ((state_reg == S_FINISH) && slot_free);

    // Shared accumulator: the ticket total while summing, the running sum while walking.
    assign run_next = ((state_reg == S_SUM) ? total_reg : run_reg) + SUM_W'(rd_tickets);

    // Memory write port: append on enqueue, move one entry down during compaction.
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = occ_reg[IDX_W-1:0];
        wr_id      = ID_BITS'(req.entry_id);
        wr_tickets = req.ticket_count;
        if (accept && (req.operation == OP_ENQUEUE) && (occ_reg != CNT_W'(QUEUE_DEPTH)))
        begin
            wr_en = 1'b1;
        end
        else if ((state_reg == S_SHIFT) && pend_reg)
        begin
            wr_en      = 1'b1;
            wr_addr    = data_idx_reg - 1'b1;
            wr_id      = rd_id;
            wr_tickets = rd_tickets;
        end
    end

    lrq_store #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_id     (wr_id),
        .wr_tickets(wr_tickets),
        .rd_addr   (issue_reg[IDX_W-1:0]),
        .rd_id     (rd_id),
        .rd_tickets(rd_tickets)
    );

    lrq_modulo #(
        .SUM_W(SUM_W)
    ) u_modulo (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (rnd_reg),
        .divisor  (total_reg),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    // Sequencer with its working registers and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        rsp_reg.winner_id      <= '0;
                        rsp_reg.winner_tickets <= '0;
                        if (req.operation == OP_ENQUEUE)
                        begin
                            if (occ_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                rsp_reg.status      <= ST_FULL;
                                rsp_reg.queue_count <= COUNT_W'(occ_reg);
                            end
                            else
                            begin
                                occ_reg             <= occ_reg + 1'b1;
                                rsp_reg.status      <= ST_ENQUEUED;
                                rsp_reg.queue_count <= COUNT_W'(occ_reg + 1'b1);
                            end
                        end
                        else if (occ_reg == '0)
                        begin
                            rsp_reg.status      <= ST_EMPTY;
                            rsp_reg.queue_count <= COUNT_W'(occ_reg);
                        end
                        else
                        begin
                            rnd_reg   <= req.random_value;
                            total_reg <= '0;
                            issue_reg <= '0;
                            pend_reg  <= 1'b0;
                            state_reg <= S_SUM;
                        end
                    end
                end

                S_SUM:
                begin
                    if (pass_done)
                    begin
                        if (total_reg == '0)
                        begin
                            st_reg    <= ST_ZERO;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_MOD;
                        end
                    end
                    else
                    begin
                        issue_reg <= issue_more ? issue_reg + 1'b1 : issue_reg;
                        pend_reg  <= issue_more;
                        if (pend_reg)
                        begin
                            total_reg <= run_next;
                        end
                    end
                end

                S_MOD:
                begin
                    if (mod_done)
                    begin
                        issue_reg <= '0;
                        pend_reg  <= 1'b0;
                        run_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_WALK;
                    end
                end

                S_WALK:
                begin
                    if (found_reg || pass_done)
                    begin
                        issue_reg <= CNT_W'(win_idx_reg) + CNT_W'(1);
                        pend_reg  <= 1'b0;
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        pend_reg <= issue_more;
                        if (issue_more)
                        begin
                            issue_reg    <= issue_reg + 1'b1;
                            data_idx_reg <= issue_reg[IDX_W-1:0];
                        end
                        // The first entry whose running sum passes the drawn ticket wins.
                        if (pend_reg)
                        begin
                            run_reg     <= run_next;
                            win_idx_reg <= data_idx_reg;
                            win_id_reg  <= rd_id;
                            win_tk_reg  <= rd_tickets;
                            found_reg   <= run_next > mod_rem;
                        end
                    end
                end

                S_SHIFT:
                begin
                    if (pass_done)
                    begin
                        occ_reg   <= occ_reg - 1'b1;
                        st_reg    <= ST_DRAWN;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        pend_reg <= issue_more;
                        if (issue_more)
                        begin
                            issue_reg    <= issue_reg + 1'b1;
                            data_idx_reg <= issue_reg[IDX_W-1:0];
                        end
                    end
                end

                S_FINISH:
                begin
                    if (slot_free)
                    begin
                        rsp_reg.status      <= st_reg;
                        rsp_reg.queue_count <= COUNT_W'(occ_reg);
                        if (st_reg == ST_DRAWN)
                        begin
                            rsp_reg.winner_id      <= IN_ID_W'(win_id_reg);
                            rsp_reg.winner_tickets <= win_tk_reg;
                        end
                        else
                        begin
                            rsp_reg.winner_id      <= '0;
                            rsp_reg.winner_tickets <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The queue never holds more entries than it has room for.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy exceeds queue depth");

    // An accepted item either produces its result at once or starts a draw.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (rsp_valid_reg || state_reg == S_SUM))
        else $error("accepted item made no progress");

    // The modulo is only run against a nonzero ticket total.
    a_mod_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> (total_reg != '0))
        else $error("modulo by zero ticket total");

    // A chosen winner's running sum lies past the drawn ticket.
    a_winner_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && found_reg) |-> (run_reg > mod_rem))
        else $error("winner chosen below drawn ticket");

    // A draw that removes an entry always leaves the queue one shorter.
    a_draw_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && pass_done) |=> (occ_reg == $past(occ_reg) - 1'b1))
        else $error("draw did not remove exactly one entry");

endmodule

/* verif/tb_lottery_ready_queue_pick.sv */
// Self-checking testbench for the lottery ready-queue picker.
`timescale 1ns / 1ps
module tb_lottery_ready_queue_pick;
    import lrq_pkg::*;

    localparam int QDEPTH = QUEUE_DEPTH_DEF;
    localparam logic [IN_ID_W-1:0] ID_MASK = IN_ID_W'((1 << ID_BITS_DEF) - 1);

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    // Shadow copy of the ready queue, head at index 0.
    logic [IN_ID_W-1:0]  held_ids     [QDEPTH];
    logic [TICKET_W-1:0] held_tickets [QDEPTH];
    int                  held_count = 0;

    rsp_item_t expected_rsp[$];
    rsp_item_t oldest_rsp;
    int        mismatches = 0;
    int        items_sent = 0;
    int        status_seen[8];
    bit        no_idle    = 1'b0;
    int        stall_left = 0;

    lottery_ready_queue_pick dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle length: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic req_item_t make_item(input logic op, input logic [IN_ID_W-1:0] id,
                                            input logic [TICKET_W-1:0] tk,
                                            input logic [RAND_W-1:0] rnd);
        req_item_t it;
        it.operation    = op;
        it.entry_id     = id;
        it.ticket_count = tk;
        it.random_value = rnd;
        return it;
    endfunction

    function automatic int count_zero_entries();
        int zeros;
        zeros = 0;
        for (int i = 0; i < held_count; i++)
            if (held_tickets[i] == '0) zeros++;
        return zeros;
    endfunction

    // Applies one item to the shadow queue and returns the result it must produce.
    function automatic rsp_item_t lottery_outcome(input req_item_t it);
        rsp_item_t   res;
        int unsigned total;
        int unsigned drawn;
        int unsigned running;
        int          win;
        res     = '0;
        total   = 0;
        running = 0;
        win     = -1;
        if (it.operation == OP_ENQUEUE)
        begin
            if (held_count >= QDEPTH)
                res.status = ST_FULL;
            else
            begin
                held_ids[held_count]     = it.entry_id & ID_MASK;
                held_tickets[held_count] = it.ticket_count;
                held_count++;
                res.status = ST_ENQUEUED;
            end
        end
        else if (held_count == 0)
            res.status = ST_EMPTY;
        else
        begin
            for (int i = 0; i < held_count; i++)
                total += held_tickets[i];
            if (total == 0)
                res.status = ST_ZERO;
            else
            begin
                // Walk from the head until the running sum passes the drawn ticket.
                drawn = it.random_value % total;
                for (int i = 0; i < held_count && win < 0; i++)
                begin
                    running += held_tickets[i];
                    if (running > drawn) win = i;
                end
                res.status         = ST_DRAWN;
                res.winner_id      = held_ids[win];
                res.winner_tickets = held_tickets[win];
                for (int i = win; i + 1 < held_count; i++)
                begin
                    held_ids[i]     = held_ids[i + 1];
                    held_tickets[i] = held_tickets[i + 1];
                end
                held_count--;
            end
        end
        res.queue_count = COUNT_W'(held_count);
        return res;
    endfunction

    // Presents one item after a random gap and records its expected result once taken.
    // Valid stays high after acceptance so that back-to-back items need no second update.
    task automatic send_item(input req_item_t it);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        expected_rsp.push_back(lottery_outcome(it));
        items_sent++;
    endtask

    // Holds the sender off until every outstanding result has been checked.
    task automatic wait_for_results(input int settle);
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Result-side back-pressure.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= pick_gap();
        end
        else
            rsp_ready <= 1'b1;
    end

    // Compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            status_seen[rsp.status]++;
            if (expected_rsp.size() == 0)
            begin
                $error("unexpected result item: status %0d", rsp.status);
                mismatches++;
            end
            else
            begin
                oldest_rsp = expected_rsp.pop_front();
                if (rsp.status !== oldest_rsp.status)
                begin
                    $error("status: expected %0d, actual %0d", oldest_rsp.status, rsp.status);
                    mismatches++;
                end
                if (rsp.winner_id !== oldest_rsp.winner_id)
                begin
                    $error("winner_id: expected %0d, actual %0d",
                           oldest_rsp.winner_id, rsp.winner_id);
                    mismatches++;
                end
                if (rsp.winner_tickets !== oldest_rsp.winner_tickets)
                begin
                    $error("winner_tickets: expected %0d, actual %0d",
                           oldest_rsp.winner_tickets, rsp.winner_tickets);
                    mismatches++;
                end
                if (rsp.queue_count !== oldest_rsp.queue_count)
                begin
                    $error("queue_count: expected %0d, actual %0d",
                           oldest_rsp.queue_count, rsp.queue_count);
                    mismatches++;
                end
            end
        end
    end

    // A draw right after reset finds nothing to pick.
    task automatic test_empty_queue();
        send_item(make_item(OP_DRAW, 8'hFF, 8'hFF, 31'h7FFF_FFFF));
    endtask

    // A queue holding only ticketless entries cannot pick; this entry stays for good.
    task automatic test_zero_total();
        send_item(make_item(OP_ENQUEUE, 8'h00, 8'h00, 31'h0));
        send_item(make_item(OP_DRAW, 8'h00, 8'h00, 31'h0));
        send_item(make_item(OP_DRAW, 8'hFF, 8'hFF, 31'h7FFF_FFFF));
    endtask

    // A ticketless entry at the head is passed over by the walk.
    task automatic test_zero_ticket_skip();
        send_item(make_item(OP_ENQUEUE, 8'hFF, 8'hFF, 31'h7FFF_FFFF));
        send_item(make_item(OP_DRAW, 8'h5A, 8'hA5, 31'h0));
    endtask

    // Fill to capacity with one-hot and high ticket counts, then overflow.
    task automatic test_full_queue();
        for (int k = 0; k < QDEPTH - 1; k++)
            send_item(make_item(OP_ENQUEUE, 8'(k * 17 + 1),
                                (k < 8) ? 8'(1 << k) : 8'(255 - k), 31'(k)));
        send_item(make_item(OP_ENQUEUE, 8'hAA, 8'h55, 31'h5555_5555));
    endtask

    // Draws with the smallest, largest and an alternating random number.
    task automatic test_draw_extremes();
        send_item(make_item(OP_DRAW, 8'h00, 8'h00, 31'h0));
        send_item(make_item(OP_DRAW, 8'hFF, 8'hFF, 31'h7FFF_FFFF));
        send_item(make_item(OP_DRAW, 8'h3C, 8'hC3, 31'h2AAA_AAAA));
    endtask

    // Random traffic that swings the queue between nearly empty and full.
    task automatic test_random_traffic();
        bit                  filling;
        int                  zeros;
        logic                op;
        logic [TICKET_W-1:0] tk;
        logic [RAND_W-1:0]   rnd;
        filling = 1'b0;
        for (int chunk = 0; chunk < 11; chunk++)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 100; n++)
            begin
                zeros = count_zero_entries();
                if (held_count >= QDEPTH)
                    filling = 1'b0;
                else if (held_count <= zeros)
                    filling = 1'b1;
                if ($urandom_range(0, 9) < 8)
                    op = filling ? OP_ENQUEUE : OP_DRAW;
                else
                    op = filling ? OP_DRAW : OP_ENQUEUE;
                tk = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 3))
                                                 : 8'($urandom_range(1, 255));
                // Ticketless entries never leave, so only a few are let in.
                if (zeros < 3 && $urandom_range(0, 99) == 0)
                    tk = '0;
                case ($urandom_range(0, 19))
                    0:       rnd = '0;
                    1, 2:    rnd = '1;
                    3, 4, 5: rnd = 31'($urandom_range(0, 4095));
                    default: rnd = 31'($urandom());
                endcase
                send_item(make_item(op, 8'($urandom()), tk, rnd));
            end
            if (chunk % 4 == 3)
                wait_for_results(0);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_zero_total();
        test_zero_ticket_skip();
        test_full_queue();
        test_draw_extremes();
        test_random_traffic();
        wait_for_results(100);
        $display("Run covered %0d items: %0d enqueued, %0d picks, %0d on empty queue,",
                 items_sent, status_seen[ST_ENQUEUED], status_seen[ST_DRAWN],
                 status_seen[ST_EMPTY]);
        $display("%0d refused as full, %0d with no tickets held; %0d mismatches.",
                 status_seen[ST_FULL], status_seen[ST_ZERO], mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
